// File: rtl/cbct_pkg.sv
// cbct_pkg: types and constants shared by the color box centroid tracker
// no dependencies; used by every module of the tracker

package cbct_pkg;

    localparam int CHAN_W    = 8;
    localparam int COORD_W   = 11;
    localparam int SUM_W     = 34;
    localparam int COUNT_W   = 23;
    localparam int CFG_IDX_W = 3;
    localparam int LIMIT_W   = 13;

    // frame limits; coordinates at or beyond them are not accumulated
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // one quotient bit per divider step
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CHAN_W-1:0] MATCH_BLUE  = 8'd0;
    localparam logic [CHAN_W-1:0] MATCH_GREEN = 8'd0;
    localparam logic [CHAN_W-1:0] MATCH_RED   = 8'd255;

    localparam logic [CHAN_W-1:0] RST_TARGET_RED      = 8'd0;
    localparam logic [CHAN_W-1:0] RST_TARGET_GREEN    = 8'd255;
    localparam logic [CHAN_W-1:0] RST_TARGET_BLUE     = 8'd0;
    localparam logic [CHAN_W-1:0] RST_TOLERANCE_RED   = 8'd15;
    localparam logic [CHAN_W-1:0] RST_TOLERANCE_GREEN = 8'd26;
    localparam logic [CHAN_W-1:0] RST_TOLERANCE_BLUE  = 8'd40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_RED      = 3'd0,
        CFG_TARGET_GREEN    = 3'd1,
        CFG_TARGET_BLUE     = 3'd2,
        CFG_TOLERANCE_RED   = 3'd3,
        CFG_TOLERANCE_GREEN = 3'd4,
        CFG_TOLERANCE_BLUE  = 3'd5
    } t_cfg_index;

    // classified pixel word passed from front to back
    typedef struct packed {
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               eof;
        logic               hit;
        logic               in_range;
    } t_item;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } t_back_state;

endpackage

// File: rtl/color_box_centroid_tracker.sv
// color_box_centroid_tracker: top level, front classifier, word queue and accumulating back end
// depends on cbct_pkg, cbct_front, cbct_fifo, cbct_back
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------------
//  pixel in | i_valid / o_ready       | i_in_blue i_in_green i_in_red i_pixel_x
//           |                         | i_pixel_y i_end_of_frame
//  result   | o_valid / i_ready       | o_out_blue o_out_green o_out_red o_matched
//           |                         | o_centroid_x o_centroid_y o_centroid_valid
//           |                         | o_frame_done
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_index i_cfg_data
//
// a pixel without end_of_frame shows its word in the cycle after it leaves the queue,
// so a stream runs at one word per cycle while the result side takes words and no division runs
// an end_of_frame word with matches waits for the 34-step divider
// reset is synchronous; it restores the color box registers and clears the sums
// the queue keeps taking pixels while the result side stalls, until it is full

module color_box_centroid_tracker #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_blue,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_red,
    input  logic [10:0] i_pixel_x,
    input  logic [10:0] i_pixel_y,
    input  logic        i_end_of_frame,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_red,
    output logic        o_matched,
    output logic [10:0] o_centroid_x,
    output logic [10:0] o_centroid_y,
    output logic        o_centroid_valid,
    output logic        o_frame_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    cbct_pkg::t_item w_front_item, w_queue_item;
    logic            w_full, w_queue_valid, w_pop;

    cbct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_blue      (i_in_blue),
        .i_green     (i_in_green),
        .i_red       (i_in_red),
        .i_x         (i_pixel_x),
        .i_y         (i_pixel_y),
        .i_eof       (i_end_of_frame),
        .o_item      (w_front_item)
    );

    cbct_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item)
    );

    assign o_ready = !w_full;

    cbct_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (w_queue_valid),
        .i_item           (w_queue_item),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_blue           (o_out_blue),
        .o_green          (o_out_green),
        .o_red            (o_out_red),
        .o_matched        (o_matched),
        .o_centroid_x     (o_centroid_x),
        .o_centroid_y     (o_centroid_y),
        .o_centroid_valid (o_centroid_valid),
        .o_frame_done     (o_frame_done)
    );

endmodule

// File: rtl/cbct_front.sv
// cbct_front: color box registers and pixel classification
// depends on cbct_pkg

module cbct_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cbct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cbct_pkg::CHAN_W-1:0]    i_cfg_data,
    input  logic [cbct_pkg::CHAN_W-1:0]    i_blue,
    input  logic [cbct_pkg::CHAN_W-1:0]    i_green,
    input  logic [cbct_pkg::CHAN_W-1:0]    i_red,
    input  logic [cbct_pkg::COORD_W-1:0]   i_x,
    input  logic [cbct_pkg::COORD_W-1:0]   i_y,
    input  logic                          i_eof,
    output cbct_pkg::t_item               o_item
);

    logic [cbct_pkg::CHAN_W-1:0] r_target_red, r_target_green, r_target_blue;
    logic [cbct_pkg::CHAN_W-1:0] r_tol_red, r_tol_green, r_tol_blue;

    // bounds in signed arithmetic, so they do not clip at 0 or 255
    function automatic logic in_box(input logic [cbct_pkg::CHAN_W-1:0] v,
                                    input logic [cbct_pkg::CHAN_W-1:0] t,
                                    input logic [cbct_pkg::CHAN_W-1:0] tol);
        logic signed [cbct_pkg::CHAN_W+1:0] lo;
        logic signed [cbct_pkg::CHAN_W+1:0] hi;
        logic signed [cbct_pkg::CHAN_W+1:0] s;
        lo = $signed({2'b00, t}) - $signed({2'b00, tol});
        hi = $signed({2'b00, t}) + $signed({2'b00, tol});
        s  = $signed({2'b00, v});
        return (s >= lo) && (s <= hi);
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_red   <= cbct_pkg::RST_TARGET_RED;
            r_target_green <= cbct_pkg::RST_TARGET_GREEN;
            r_target_blue  <= cbct_pkg::RST_TARGET_BLUE;
            r_tol_red      <= cbct_pkg::RST_TOLERANCE_RED;
            r_tol_green    <= cbct_pkg::RST_TOLERANCE_GREEN;
            r_tol_blue     <= cbct_pkg::RST_TOLERANCE_BLUE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cbct_pkg::CFG_TARGET_RED:      r_target_red   <= i_cfg_data;
                cbct_pkg::CFG_TARGET_GREEN:    r_target_green <= i_cfg_data;
                cbct_pkg::CFG_TARGET_BLUE:     r_target_blue  <= i_cfg_data;
                cbct_pkg::CFG_TOLERANCE_RED:   r_tol_red      <= i_cfg_data;
                cbct_pkg::CFG_TOLERANCE_GREEN: r_tol_green    <= i_cfg_data;
                cbct_pkg::CFG_TOLERANCE_BLUE:  r_tol_blue     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_item.blue  = i_blue;
        o_item.green = i_green;
        o_item.red   = i_red;
        o_item.x     = i_x;
        o_item.y     = i_y;
        o_item.eof   = i_eof;
        o_item.hit   = in_box(i_blue, r_target_blue, r_tol_blue)
                    && in_box(i_green, r_target_green, r_tol_green)
                    && in_box(i_red, r_target_red, r_tol_red);
        o_item.in_range =
            ({{(cbct_pkg::LIMIT_W-cbct_pkg::COORD_W){1'b0}}, i_x}
                < cbct_pkg::LIMIT_W'(cbct_pkg::MAX_WIDTH))
            && ({{(cbct_pkg::LIMIT_W-cbct_pkg::COORD_W){1'b0}}, i_y}
                < cbct_pkg::LIMIT_W'(cbct_pkg::MAX_HEIGHT));
    end

endmodule

// File: rtl/cbct_fifo.sv
// cbct_fifo: short word queue between the front and back parts
// depends on cbct_pkg for the word type

module cbct_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cbct_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cbct_pkg::t_item o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cbct_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/cbct_div.sv
// cbct_div: restoring divider, one quotient bit per cycle, two dividends over one divisor
// depends on cbct_pkg; keeps only the low coordinate bits of each quotient

module cbct_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cbct_pkg::SUM_W-1:0]    i_num_x,
    input  logic [cbct_pkg::SUM_W-1:0]    i_num_y,
    input  logic [cbct_pkg::COUNT_W-1:0]  i_den,
    output logic                          o_busy,
    output logic [cbct_pkg::COORD_W-1:0]  o_quot_x,
    output logic [cbct_pkg::COORD_W-1:0]  o_quot_y
);

    logic                             r_busy;
    logic [cbct_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [cbct_pkg::SUM_W-1:0]       r_num_x, r_num_y;
    logic [cbct_pkg::COUNT_W-1:0]     r_rem_x, r_rem_y, r_den;
    logic [cbct_pkg::COORD_W-1:0]     r_q_x, r_q_y;
    logic [cbct_pkg::COUNT_W:0]       w_trial_x, w_trial_y, w_diff_x, w_diff_y;
    logic                             w_ge_x, w_ge_y;

    always_comb begin
        w_trial_x = {r_rem_x, r_num_x[cbct_pkg::SUM_W-1]};
        w_trial_y = {r_rem_y, r_num_y[cbct_pkg::SUM_W-1]};
        w_diff_x  = w_trial_x - {1'b0, r_den};
        w_diff_y  = w_trial_y - {1'b0, r_den};
        w_ge_x    = (w_trial_x >= {1'b0, r_den});
        w_ge_y    = (w_trial_y >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == cbct_pkg::DIV_CNT_W'(cbct_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num_x <= i_num_x;
            r_num_y <= i_num_y;
            r_den   <= i_den;
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_q_x   <= '0;
            r_q_y   <= '0;
        end else if (r_busy) begin
            r_num_x <= {r_num_x[cbct_pkg::SUM_W-2:0], 1'b0};
            r_num_y <= {r_num_y[cbct_pkg::SUM_W-2:0], 1'b0};
            // remainder stays below the divisor, so the top trial bit drops out
            r_rem_x <= w_ge_x ? w_diff_x[cbct_pkg::COUNT_W-1:0]
                              : w_trial_x[cbct_pkg::COUNT_W-1:0];
            r_rem_y <= w_ge_y ? w_diff_y[cbct_pkg::COUNT_W-1:0]
                              : w_trial_y[cbct_pkg::COUNT_W-1:0];
            r_q_x   <= {r_q_x[cbct_pkg::COORD_W-2:0], w_ge_x};
            r_q_y   <= {r_q_y[cbct_pkg::COORD_W-2:0], w_ge_y};
        end
    end

    assign o_busy   = r_busy;
    assign o_quot_x = r_q_x;
    assign o_quot_y = r_q_y;

endmodule

// File: rtl/cbct_back.sv
// cbct_back: accumulates matched coordinates, forms the centroid and holds the result word
// depends on cbct_pkg and cbct_div

module cbct_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  cbct_pkg::t_item               i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cbct_pkg::CHAN_W-1:0]   o_blue,
    output logic [cbct_pkg::CHAN_W-1:0]   o_green,
    output logic [cbct_pkg::CHAN_W-1:0]   o_red,
    output logic                          o_matched,
    output logic [cbct_pkg::COORD_W-1:0]  o_centroid_x,
    output logic [cbct_pkg::COORD_W-1:0]  o_centroid_y,
    output logic                          o_centroid_valid,
    output logic                          o_frame_done
);

    cbct_pkg::t_back_state            r_state, n_state;
    logic [cbct_pkg::SUM_W-1:0]       r_sum_x, r_sum_y, n_sum_x, n_sum_y;
    logic [cbct_pkg::COUNT_W-1:0]     r_count, n_count;
    logic                             r_out_valid;
    logic [cbct_pkg::CHAN_W-1:0]      r_blue, r_green, r_red;
    logic                             r_matched, r_cv, r_fd;
    logic [cbct_pkg::COORD_W-1:0]     r_cx, r_cy;
    logic                             w_out_free, w_pop, w_add, w_div_start, w_load_cent;
    logic                             w_div_busy;
    logic [cbct_pkg::COORD_W-1:0]     w_quot_x, w_quot_y;

    cbct_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num_x  (n_sum_x),
        .i_num_y  (n_sum_y),
        .i_den    (n_count),
        .o_busy   (w_div_busy),
        .o_quot_x (w_quot_x),
        .o_quot_y (w_quot_y)
    );

    // control outputs of the sequencer
    always_comb begin
        w_out_free  = !r_out_valid || i_ready;
        w_pop       = (r_state == cbct_pkg::ST_IDLE) && i_item_valid && w_out_free;
        w_add       = i_item.hit && i_item.in_range;
        n_sum_x     = r_sum_x + (w_add ? {{(cbct_pkg::SUM_W-cbct_pkg::COORD_W){1'b0}}, i_item.x}
                                       : '0);
        n_sum_y     = r_sum_y + (w_add ? {{(cbct_pkg::SUM_W-cbct_pkg::COORD_W){1'b0}}, i_item.y}
                                       : '0);
        n_count     = r_count + {{(cbct_pkg::COUNT_W-1){1'b0}}, w_add};
        // empty frame skips the divider
        w_div_start = w_pop && i_item.eof && (n_count != '0);
        w_load_cent = (r_state == cbct_pkg::ST_DIV) && !w_div_busy && w_out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cbct_pkg::ST_IDLE: begin
                if (w_div_start) begin
                    n_state = cbct_pkg::ST_DIV;
                end
            end
            cbct_pkg::ST_DIV: begin
                if (w_load_cent) begin
                    n_state = cbct_pkg::ST_IDLE;
                end
            end
            default: n_state = cbct_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cbct_pkg::ST_IDLE;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_pop) begin
                if (i_item.eof) begin
                    r_sum_x <= '0;
                    r_sum_y <= '0;
                    r_count <= '0;
                end else begin
                    r_sum_x <= n_sum_x;
                    r_sum_y <= n_sum_y;
                    r_count <= n_count;
                end
            end
            if (w_pop) begin
                r_out_valid <= !w_div_start;
            end else if (w_load_cent) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pixel part is written on pop, centroid part when the divider has finished and the output is free
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_blue    <= i_item.hit ? cbct_pkg::MATCH_BLUE  : i_item.blue;
            r_green   <= i_item.hit ? cbct_pkg::MATCH_GREEN : i_item.green;
            r_red     <= i_item.hit ? cbct_pkg::MATCH_RED   : i_item.red;
            r_matched <= i_item.hit;
            r_fd      <= i_item.eof;
            r_cx      <= '0;
            r_cy      <= '0;
            r_cv      <= 1'b0;
        end else if (w_load_cent) begin
            r_cx <= w_quot_x;
            r_cy <= w_quot_y;
            r_cv <= 1'b1;
        end
    end

    assign o_pop            = w_pop;
    assign o_valid          = r_out_valid;
    assign o_blue           = r_blue;
    assign o_green          = r_green;
    assign o_red            = r_red;
    assign o_matched        = r_matched;
    assign o_centroid_x     = r_cx;
    assign o_centroid_y     = r_cy;
    assign o_centroid_valid = r_cv;
    assign o_frame_done     = r_fd;

    a_div_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cbct_pkg::ST_DIV |-> !r_out_valid)
        else $error("result word shown while centroid division runs");

    a_pixel_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && !i_item.eof |=> r_out_valid)
        else $error("popped pixel did not reach the output register");

    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> r_state == cbct_pkg::ST_DIV)
        else $error("divider busy outside the division state");

    a_cv_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_cv |-> r_fd)
        else $error("centroid marked valid on a word that does not end a frame");

endmodule

// File: sim/tb.sv
// tb: self-checking bench for color_box_centroid_tracker, recolor and frame centroid paths
// depends on cbct_pkg and the tracker rtl; drives pixels in bursts, checks every result word

module tb;

    typedef logic [cbct_pkg::CHAN_W-1:0]    t_chan;
    typedef logic [cbct_pkg::COORD_W-1:0]   t_coord;
    typedef logic [cbct_pkg::SUM_W-1:0]     t_sum;
    typedef logic [cbct_pkg::COUNT_W-1:0]   t_count;
    typedef logic [cbct_pkg::CFG_IDX_W-1:0] t_idx;

    localparam t_idx CFG_SPARE_LO = 3'd6;
    localparam t_idx CFG_SPARE_HI = 3'd7;
    localparam int NUM_REGS     = 6;
    localparam int PHASE_PIXELS = 205;
    localparam int NUM_PHASES   = 8;
    localparam int TAIL_CYCLES  = 48;

    typedef struct {
        t_chan  blue;
        t_chan  green;
        t_chan  red;
        t_coord x;
        t_coord y;
        logic   eof;
    } t_pixel;

    typedef struct {
        t_chan  blue;
        t_chan  green;
        t_chan  red;
        logic   matched;
        t_coord cx;
        t_coord cy;
        logic   cvalid;
        logic   done;
    } t_pixel_res;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_BURSTY,
        RX_SPARSE
    } t_rx_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_in_blue;
    logic [7:0]         i_in_green;
    logic [7:0]         i_in_red;
    logic [10:0]        i_pixel_x;
    logic [10:0]        i_pixel_y;
    logic               i_end_of_frame;
    logic               o_valid;
    logic               i_ready;
    logic [7:0]         o_out_blue;
    logic [7:0]         o_out_green;
    logic [7:0]         o_out_red;
    logic               o_matched;
    logic [10:0]        o_centroid_x;
    logic [10:0]        o_centroid_y;
    logic               o_centroid_valid;
    logic               o_frame_done;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [7:0]         i_cfg_data;

    // shadow of the color box registers and the frame accumulators
    t_chan      box_reg [NUM_REGS];
    t_sum       sum_x;
    t_sum       sum_y;
    t_count     hits;

    t_pixel     pixel_in_q  [$];
    t_pixel_res pixel_out_q [$];
    int         mismatches;

    t_pixel     cur_px;
    int         burst_left;
    int         gap_left;
    t_rx_mode   rx_mode;
    int         rx_mode_left;
    int         stall_left;

    color_box_centroid_tracker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_in_blue        (i_in_blue),
        .i_in_green       (i_in_green),
        .i_in_red         (i_in_red),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .i_end_of_frame   (i_end_of_frame),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_blue       (o_out_blue),
        .o_out_green      (o_out_green),
        .o_out_red        (o_out_red),
        .o_matched        (o_matched),
        .o_centroid_x     (o_centroid_x),
        .o_centroid_y     (o_centroid_y),
        .o_centroid_valid (o_centroid_valid),
        .o_frame_done     (o_frame_done),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // bounds are signed, so target - tol below zero or target + tol above 255 do not limit
    function automatic logic in_box(input t_chan v, input t_chan tgt, input t_chan tol);
        int s;
        int t;
        int w;
        s = int'(v);
        t = int'(tgt);
        w = int'(tol);
        return (s >= t - w) && (s <= t + w);
    endfunction

    function automatic t_pixel_res recolor_and_track(input t_pixel p);
        t_pixel_res r;
        logic       hit;
        t_sum       quo_x;
        t_sum       quo_y;
        hit = in_box(p.blue, box_reg[cbct_pkg::CFG_TARGET_BLUE],
                     box_reg[cbct_pkg::CFG_TOLERANCE_BLUE]) &&
              in_box(p.green, box_reg[cbct_pkg::CFG_TARGET_GREEN],
                     box_reg[cbct_pkg::CFG_TOLERANCE_GREEN]) &&
              in_box(p.red, box_reg[cbct_pkg::CFG_TARGET_RED],
                     box_reg[cbct_pkg::CFG_TOLERANCE_RED]);
        r.blue    = hit ? cbct_pkg::MATCH_BLUE  : p.blue;
        r.green   = hit ? cbct_pkg::MATCH_GREEN : p.green;
        r.red     = hit ? cbct_pkg::MATCH_RED   : p.red;
        r.matched = hit;
        r.cx      = '0;
        r.cy      = '0;
        r.cvalid  = 1'b0;
        r.done    = p.eof;
        if (hit && int'(p.x) < cbct_pkg::MAX_WIDTH && int'(p.y) < cbct_pkg::MAX_HEIGHT) begin
            sum_x = sum_x + t_sum'(p.x);
            sum_y = sum_y + t_sum'(p.y);
            hits  = hits + t_count'(1);
        end
        // the last pixel is counted before the centroid is formed
        if (p.eof) begin
            if (hits != '0) begin
                quo_x    = sum_x / t_sum'(hits);
                quo_y    = sum_y / t_sum'(hits);
                r.cx     = quo_x[cbct_pkg::COORD_W-1:0];
                r.cy     = quo_y[cbct_pkg::COORD_W-1:0];
                r.cvalid = 1'b1;
            end
            sum_x = '0;
            sum_y = '0;
            hits  = '0;
        end
        return r;
    endfunction

    // pixel driver: bursts of random length, gaps of random length, sometimes none
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end else begin
            if (i_valid && o_ready) begin
                pixel_out_q.push_back(recolor_and_track(cur_px));
            end
            if (!i_valid || o_ready) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pixel_in_q.size() != 0) begin
                    cur_px = pixel_in_q.pop_front();
                    i_in_blue      <= cur_px.blue;
                    i_in_green     <= cur_px.green;
                    i_in_red       <= cur_px.red;
                    i_pixel_x      <= cur_px.x;
                    i_pixel_y      <= cur_px.y;
                    i_end_of_frame <= cur_px.eof;
                    i_valid        <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result side: stall mode changes whenever its random hold count runs out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready      <= 1'b0;
            rx_mode      = RX_FREE;
            rx_mode_left = 0;
            stall_left   = 0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(50, 400);
            end else begin
                rx_mode_left = rx_mode_left - 1;
            end
            if (stall_left != 0) begin
                stall_left = stall_left - 1;
                i_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE: begin
                        i_ready <= 1'b1;
                    end
                    RX_COIN: begin
                        i_ready <= ($urandom_range(0, 1) == 1);
                    end
                    RX_BURSTY: begin
                        i_ready <= 1'b1;
                        if ($urandom_range(0, 15) == 0) begin
                            stall_left = $urandom_range(1, 40);
                        end
                    end
                    default: begin
                        i_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_res w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pixel_out_q.size() == 0) begin
                $error("result word with nothing outstanding");
                mismatches++;
            end else begin
                w = pixel_out_q.pop_front();
                check_field("out_blue", 32'(w.blue), 32'(o_out_blue));
                check_field("out_green", 32'(w.green), 32'(o_out_green));
                check_field("out_red", 32'(w.red), 32'(o_out_red));
                check_field("matched", 32'(w.matched), 32'(o_matched));
                check_field("centroid_x", 32'(w.cx), 32'(o_centroid_x));
                check_field("centroid_y", 32'(w.cy), 32'(o_centroid_y));
                check_field("centroid_valid", 32'(w.cvalid), 32'(o_centroid_valid));
                check_field("frame_done", 32'(w.done), 32'(o_frame_done));
            end
        end
    end

    task automatic write_reg(input t_idx idx, input t_chan val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        // indexes past the register list are dropped by the block
        if (int'(idx) < NUM_REGS) begin
            box_reg[idx] = val;
        end
    endtask

    task automatic set_box(input int phase);
        t_chan tg [3];
        t_chan tl [3];
        int    k;
        for (k = 0; k < 3; k++) begin
            case (phase)
                0: begin tg[k] = 8'd0;   tl[k] = 8'd255; end
                1: begin tg[k] = 8'd255; tl[k] = 8'd0;   end
                2: begin tg[k] = 8'd0;   tl[k] = 8'd0;   end
                3: begin tg[k] = 8'd255; tl[k] = 8'd255; end
                default: begin
                    tg[k] = t_chan'($urandom_range(0, 255));
                    tl[k] = t_chan'($urandom_range(0, 60));
                end
            endcase
        end
        write_reg(cbct_pkg::CFG_TARGET_RED, tg[0]);
        write_reg(cbct_pkg::CFG_TARGET_GREEN, tg[1]);
        write_reg(cbct_pkg::CFG_TARGET_BLUE, tg[2]);
        write_reg(cbct_pkg::CFG_TOLERANCE_RED, tl[0]);
        write_reg(cbct_pkg::CFG_TOLERANCE_GREEN, tl[1]);
        write_reg(cbct_pkg::CFG_TOLERANCE_BLUE, tl[2]);
        if (phase == 1 || phase == 5) begin
            write_reg(CFG_SPARE_LO, t_chan'($urandom_range(0, 255)));
            write_reg(CFG_SPARE_HI, t_chan'($urandom_range(0, 255)));
        end
    endtask

    task automatic add_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                             input logic [10:0] x, input logic [10:0] y, input logic eof);
        t_pixel p;
        p.blue  = b;
        p.green = g;
        p.red   = r;
        p.x     = x;
        p.y     = y;
        p.eof   = eof;
        pixel_in_q.push_back(p);
    endtask

    // channel value inside the box or just past one of its edges
    function automatic t_chan near_box(input t_chan tgt, input t_chan tol);
        int v;
        if ($urandom_range(0, 1) == 1) begin
            v = int'(tgt) - int'(tol) - 2 + int'($urandom_range(0, 2 * tol + 4));
        end else begin
            v = (($urandom_range(0, 1) == 1) ? int'(tgt) + int'(tol) : int'(tgt) - int'(tol))
                + int'($urandom_range(0, 2)) - 1;
        end
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[cbct_pkg::CHAN_W-1:0];
    endfunction

    task automatic queue_frames(input int n);
        int     left;
        int     len;
        int     k;
        logic   noisy;
        t_pixel p;
        left = n;
        while (left > 0) begin
            len = $urandom_range(1, 24);
            if (len > left) len = left;
            noisy = ($urandom_range(0, 7) == 0);
            for (k = 0; k < len; k++) begin
                if (!noisy && $urandom_range(0, 4) < 3) begin
                    p.blue  = near_box(box_reg[cbct_pkg::CFG_TARGET_BLUE],
                                       box_reg[cbct_pkg::CFG_TOLERANCE_BLUE]);
                    p.green = near_box(box_reg[cbct_pkg::CFG_TARGET_GREEN],
                                       box_reg[cbct_pkg::CFG_TOLERANCE_GREEN]);
                    p.red   = near_box(box_reg[cbct_pkg::CFG_TARGET_RED],
                                       box_reg[cbct_pkg::CFG_TOLERANCE_RED]);
                end else begin
                    p.blue  = t_chan'($urandom_range(0, 255));
                    p.green = t_chan'($urandom_range(0, 255));
                    p.red   = t_chan'($urandom_range(0, 255));
                end
                p.x   = t_coord'($urandom_range(0, 2047));
                p.y   = t_coord'($urandom_range(0, 2047));
                p.eof = (k == len - 1);
                pixel_in_q.push_back(p);
            end
            left = left - len;
        end
    endtask

    // sampled away from the rising edge so the driver and monitor have settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (pixel_in_q.size() != 0 || i_valid || pixel_out_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int ph;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_in_blue      = '0;
        i_in_green     = '0;
        i_in_red       = '0;
        i_pixel_x      = '0;
        i_pixel_y      = '0;
        i_end_of_frame = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        mismatches     = 0;
        box_reg[cbct_pkg::CFG_TARGET_RED]      = cbct_pkg::RST_TARGET_RED;
        box_reg[cbct_pkg::CFG_TARGET_GREEN]    = cbct_pkg::RST_TARGET_GREEN;
        box_reg[cbct_pkg::CFG_TARGET_BLUE]     = cbct_pkg::RST_TARGET_BLUE;
        box_reg[cbct_pkg::CFG_TOLERANCE_RED]   = cbct_pkg::RST_TOLERANCE_RED;
        box_reg[cbct_pkg::CFG_TOLERANCE_GREEN] = cbct_pkg::RST_TOLERANCE_GREEN;
        box_reg[cbct_pkg::CFG_TOLERANCE_BLUE]  = cbct_pkg::RST_TOLERANCE_BLUE;
        sum_x = '0;
        sum_y = '0;
        hits  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset box: green 255 +/-26, red 0 +/-15, blue 0 +/-40
        add_pixel(8'd0, 8'd255, 8'd0, 11'd0, 11'd0, 1'b0);
        add_pixel(8'd0, 8'd255, 8'd0, 11'd2047, 11'd2047, 1'b0);
        add_pixel(8'd40, 8'd229, 8'd15, 11'd1024, 11'd1, 1'b0);
        add_pixel(8'd41, 8'd229, 8'd15, 11'd5, 11'd5, 1'b0);
        add_pixel(8'd40, 8'd228, 8'd15, 11'd5, 11'd5, 1'b0);
        add_pixel(8'd40, 8'd229, 8'd16, 11'd5, 11'd5, 1'b0);
        add_pixel(8'd255, 8'd255, 8'd255, 11'd2047, 11'd0, 1'b0);
        add_pixel(8'd0, 8'd0, 8'd0, 11'd0, 11'd2047, 1'b0);
        add_pixel(8'd0, 8'd255, 8'd0, 11'd3, 11'd7, 1'b1);
        // frame with no match
        add_pixel(8'd255, 8'd0, 8'd255, 11'd10, 11'd10, 1'b1);
        // end-of-frame pixel as the only match
        add_pixel(8'd20, 8'd240, 8'd5, 11'd1000, 11'd2000, 1'b1);
        // centroid truncates: 5/3 and 7/3
        add_pixel(8'd0, 8'd255, 8'd0, 11'd1, 11'd1, 1'b0);
        add_pixel(8'd0, 8'd255, 8'd0, 11'd2, 11'd2, 1'b0);
        add_pixel(8'd0, 8'd255, 8'd0, 11'd2, 11'd4, 1'b0);
        add_pixel(8'd255, 8'd255, 8'd255, 11'd0, 11'd0, 1'b1);
        add_pixel(8'd128, 8'd128, 8'd128, 11'd1365, 11'd682, 1'b1);
        add_pixel(8'd0, 8'd255, 8'd0, 11'd2047, 11'd2047, 1'b0);
        add_pixel(8'd0, 8'd255, 8'd0, 11'd2047, 11'd2047, 1'b1);
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            set_box(ph);
            queue_frames(PHASE_PIXELS);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
